FILE: hdl/ade_pkg.sv
// Package for the array deque engine: sizes, codes and beat types.
`timescale 1ns / 1ps

package ade_pkg;

  localparam int DEPTH = 128;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int WORD_W = 32;
  localparam int CNT_W = 8;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [IDX_W:0]   ptr_t;
  typedef logic signed [WORD_W-1:0] word_t;

  localparam idx_t LAST_IDX = idx_t'(DEPTH - 1);
  localparam word_t EMPTY_WORD = '1;

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_CLEAR      = 3'd4,
    REQ_REVERSE    = 3'd5,
    REQ_SORT       = 3'd6
  } req_code_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic signed [WORD_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;
    logic [CNT_W-1:0] count;
    logic is_empty;
  } rsp_t;

endpackage

FILE: hdl/array_deque_engine.sv
// Top level of the array deque engine: sequencer, word store and response register.
`timescale 1ns / 1ps

// Channel  Beat type         Handshake              Carries
// req      ade_pkg::req_t    req_valid / req_ready  one operation and its push word
// rsp      ade_pkg::rsp_t    rsp_valid / rsp_ready  status, front, back, count, empty flag
//
// Push, pop, clear and the unused code pass from the request beat to the response register
// through index update and store write, front and back read, and response load; req_ready
// rises the cycle after that load, so no new request is taken before the last one is loaded.
// Reverse reads each pair of slots from the ends inward, then writes the low and high slot.
// Sort reads each word as the key, moves each larger word below it up a slot, writes the key.
// Reset clears indices, sequencer and rsp_valid, not the store; a stalled response holds
// the sequencer in its last step, and req_ready stays low until the response moves.

module array_deque_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ade_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ade_pkg::rsp_t rsp
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_REV_RD,
    S_REV_W1,
    S_REV_W2,
    S_SRT_K,
    S_SRT_V,
    S_SRT_P,
    S_SRT_C,
    S_READ,
    S_DONE
  } state_t;

  state_t state;

  // Control registers.
  ade_pkg::idx_t head;
  ade_pkg::idx_t tail;
  logic          holds;

  // Captured request and its status.
  logic [2:0]      op;
  ade_pkg::word_t  value;
  logic [1:0]      status;

  // Walk registers for reverse and sort; lo is shared by both.
  ade_pkg::idx_t lo;    // reverse low index, or sort insertion position
  ade_pkg::idx_t hi;    // reverse high index
  ade_pkg::ptr_t k;     // sort outer index, can step one past the tail
  ade_pkg::word_t key;  // word being inserted

  // Word store with one write port and two registered read ports.
  ade_pkg::word_t storage [ade_pkg::DEPTH];
  ade_pkg::word_t rd_a;
  ade_pkg::word_t rd_b;

  logic           wr_en;
  ade_pkg::idx_t  wr_addr;
  ade_pkg::word_t wr_data;
  logic           rd_en_a;
  logic           rd_en_b;
  ade_pkg::idx_t  rd_addr_a;
  ade_pkg::idx_t  rd_addr_b;

  // The word comparator: the slot below the insertion point against the key.
  logic key_less;
  assign key_less = rd_a > key;

  ade_pkg::ptr_t count_full;
  assign count_full = holds ? ({1'b0, tail} - {1'b0, head} + ade_pkg::ptr_t'(1)) : '0;

  assign req_ready = (state == S_IDLE);

  // The response register takes a new beat when it is free or being emptied.
  logic rsp_load;
  assign rsp_load = (state == S_DONE) && (!rsp_valid || rsp_ready);

  // Store port control.
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = value;
    rd_en_a   = 1'b0;
    rd_en_b   = 1'b0;
    rd_addr_a = head;
    rd_addr_b = tail;
    unique case (state)
      S_EXEC: begin
        unique case (op)
          ade_pkg::REQ_PUSH_FRONT: begin
            if (!holds) begin
              wr_en   = 1'b1;
              wr_addr = '0;
            end else if (head != '0) begin
              wr_en   = 1'b1;
              wr_addr = head - ade_pkg::idx_t'(1);
            end
          end
          ade_pkg::REQ_PUSH_BACK: begin
            if (!holds) begin
              wr_en   = 1'b1;
              wr_addr = '0;
            end else if (tail != ade_pkg::LAST_IDX) begin
              wr_en   = 1'b1;
              wr_addr = tail + ade_pkg::idx_t'(1);
            end
          end
          default: begin
          end
        endcase
      end
      S_REV_RD: begin
        rd_en_a   = (lo < hi);
        rd_en_b   = (lo < hi);
        rd_addr_a = lo;
        rd_addr_b = hi;
      end
      S_REV_W1: begin
        wr_en   = 1'b1;
        wr_addr = lo;
        wr_data = rd_b;
      end
      S_REV_W2: begin
        wr_en   = 1'b1;
        wr_addr = hi;
        wr_data = rd_a;
      end
      S_SRT_K: begin
        rd_en_a   = (k <= {1'b0, tail});
        rd_addr_a = k[ade_pkg::IDX_W-1:0];
      end
      S_SRT_P: begin
        if (lo > head) begin
          rd_en_a   = 1'b1;
          rd_addr_a = lo - ade_pkg::idx_t'(1);
        end else begin
          wr_en   = 1'b1;
          wr_addr = lo;
          wr_data = key;
        end
      end
      S_SRT_C: begin
        wr_en   = 1'b1;
        wr_addr = lo;
        wr_data = key_less ? rd_a : key;
      end
      S_READ: begin
        rd_en_a = 1'b1;
        rd_en_b = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      storage[wr_addr] <= wr_data;
    end
    if (rd_en_a) begin
      rd_a <= storage[rd_addr_a];
    end
    if (rd_en_b) begin
      rd_b <= storage[rd_addr_b];
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      holds     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op     <= req.req_type;
            value  <= req.push_value;
            status <= ade_pkg::ST_OK;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_READ;
          unique case (op)
            ade_pkg::REQ_PUSH_FRONT: begin
              if (!holds) begin
                head  <= '0;
                tail  <= '0;
                holds <= 1'b1;
              end else if (head == '0) begin
                status <= ade_pkg::ST_OVERFLOW;
              end else begin
                head <= head - ade_pkg::idx_t'(1);
              end
            end
            ade_pkg::REQ_PUSH_BACK: begin
              if (!holds) begin
                head  <= '0;
                tail  <= '0;
                holds <= 1'b1;
              end else if (tail == ade_pkg::LAST_IDX) begin
                status <= ade_pkg::ST_OVERFLOW;
              end else begin
                tail <= tail + ade_pkg::idx_t'(1);
              end
            end
            ade_pkg::REQ_POP_FRONT, ade_pkg::REQ_POP_BACK: begin
              if (!holds) begin
                status <= ade_pkg::ST_UNDERFLOW;
              end else if (head == tail) begin
                head  <= '0;
                tail  <= '0;
                holds <= 1'b0;
              end else if (op == ade_pkg::REQ_POP_FRONT) begin
                head <= head + ade_pkg::idx_t'(1);
              end else begin
                tail <= tail - ade_pkg::idx_t'(1);
              end
            end
            ade_pkg::REQ_CLEAR: begin
              head  <= '0;
              tail  <= '0;
              holds <= 1'b0;
            end
            ade_pkg::REQ_REVERSE: begin
              lo <= head;
              hi <= tail;
              if (holds) begin
                state <= S_REV_RD;
              end
            end
            ade_pkg::REQ_SORT: begin
              k <= {1'b0, head} + ade_pkg::ptr_t'(1);
              if (holds) begin
                state <= S_SRT_K;
              end
            end
            default: begin
            end
          endcase
        end
        S_REV_RD: begin
          state <= (lo < hi) ? S_REV_W1 : S_READ;
        end
        S_REV_W1: begin
          state <= S_REV_W2;
        end
        S_REV_W2: begin
          lo    <= lo + ade_pkg::idx_t'(1);
          hi    <= hi - ade_pkg::idx_t'(1);
          state <= S_REV_RD;
        end
        S_SRT_K: begin
          state <= (k <= {1'b0, tail}) ? S_SRT_V : S_READ;
        end
        S_SRT_V: begin
          key   <= rd_a;
          lo    <= k[ade_pkg::IDX_W-1:0];
          state <= S_SRT_P;
        end
        S_SRT_P: begin
          if (lo > head) begin
            state <= S_SRT_C;
          end else begin
            k     <= k + ade_pkg::ptr_t'(1);
            state <= S_SRT_K;
          end
        end
        S_SRT_C: begin
          if (key_less) begin
            lo    <= lo - ade_pkg::idx_t'(1);
            state <= S_SRT_P;
          end else begin
            k     <= k + ade_pkg::ptr_t'(1);
            state <= S_SRT_K;
          end
        end
        S_READ: begin
          state <= S_DONE;
        end
        S_DONE: begin
          // Wait here until the response register is free or being emptied.
          if (rsp_load) begin
            rsp.status      <= status;
            rsp.front_value <= holds ? rd_a : ade_pkg::EMPTY_WORD;
            rsp.back_value  <= holds ? rd_b : ade_pkg::EMPTY_WORD;
            rsp.count       <= ade_pkg::CNT_W'(count_full);
            rsp.is_empty    <= !holds;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The held words always form one run from head to tail.
  a_run_order: assert property (@(posedge clk) disable iff (rst)
    holds |-> (head <= tail))
    else $error("head index passed tail index");

  // An empty deque parks both indices at slot zero.
  a_empty_parked: assert property (@(posedge clk) disable iff (rst)
    !holds |-> (head == '0 && tail == '0))
    else $error("empty deque with nonzero index");

  // A request beat makes the block busy on the next cycle.
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while busy");

  // A response beat never reports words and an empty flag together.
  a_rsp_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.is_empty == (rsp.count == '0)))
    else $error("empty flag disagrees with count");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the array deque engine: stimulus, shadow deque and response checks.
`timescale 1ns / 1ps

module tb_top;

  // Code 7 is not an operation; the block must answer it like a no-op.
  localparam logic [2:0] REQ_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 2000;
  localparam int MAX_ITEMS = 4096;
  localparam int IDLE_PCT = 30;
  localparam int CALM_FROM = 800;
  localparam int CALM_TO = 1100;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  ade_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  ade_pkg::rsp_t rsp;

  // Pending requests are taken in order from next_pending up to n_pending.
  ade_pkg::req_t pending_reqs[MAX_ITEMS];
  int n_pending = 0;
  int next_pending = 0;
  // Expected responses are written at exp_wr and checked from exp_rd.
  ade_pkg::rsp_t expected_rsps[MAX_ITEMS];
  int exp_wr = 0;
  int exp_rd = 0;
  int sent_count = 0;
  int got_count = 0;
  int failures = 0;
  longint cycle_count = 0;
  longint cycle_limit = 100000;

  // Shadow copy of the deque; words fill slots front_ix through back_ix.
  ade_pkg::word_t deque_words[ade_pkg::DEPTH];
  int front_ix = 0;
  int back_ix = 0;
  bit has_words = 1'b0;

  array_deque_engine i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Applies one request to the shadow deque and returns the response it must produce.
  function automatic ade_pkg::rsp_t apply_request(ade_pkg::req_t r);
    ade_pkg::rsp_t o;
    ade_pkg::word_t w;
    int k;
    int p;
    o = '0;
    o.status = ade_pkg::ST_OK;
    case (r.req_type)
      ade_pkg::REQ_PUSH_FRONT, ade_pkg::REQ_PUSH_BACK: begin
        if (!has_words) begin
          // The first word always lands in slot 0.
          front_ix = 0;
          back_ix = 0;
          has_words = 1'b1;
          deque_words[0] = r.push_value;
        end else if (r.req_type == ade_pkg::REQ_PUSH_FRONT) begin
          if (front_ix == 0) begin
            o.status = ade_pkg::ST_OVERFLOW;
          end else begin
            front_ix--;
            deque_words[front_ix] = r.push_value;
          end
        end else if (back_ix == ade_pkg::DEPTH - 1) begin
          o.status = ade_pkg::ST_OVERFLOW;
        end else begin
          back_ix++;
          deque_words[back_ix] = r.push_value;
        end
      end
      ade_pkg::REQ_POP_FRONT, ade_pkg::REQ_POP_BACK: begin
        if (!has_words) begin
          o.status = ade_pkg::ST_UNDERFLOW;
        end else if (front_ix == back_ix) begin
          has_words = 1'b0;
          front_ix = 0;
          back_ix = 0;
        end else if (r.req_type == ade_pkg::REQ_POP_FRONT) begin
          front_ix++;
        end else begin
          back_ix--;
        end
      end
      ade_pkg::REQ_CLEAR: begin
        has_words = 1'b0;
        front_ix = 0;
        back_ix = 0;
      end
      ade_pkg::REQ_REVERSE: begin
        if (has_words) begin
          for (k = 0; front_ix + k < back_ix - k; k++) begin
            w = deque_words[front_ix + k];
            deque_words[front_ix + k] = deque_words[back_ix - k];
            deque_words[back_ix - k] = w;
          end
        end
      end
      ade_pkg::REQ_SORT: begin
        if (has_words) begin
          for (k = front_ix + 1; k <= back_ix; k++) begin
            w = deque_words[k];
            p = k;
            while (p > front_ix && deque_words[p - 1] > w) begin
              deque_words[p] = deque_words[p - 1];
              p--;
            end
            deque_words[p] = w;
          end
        end
      end
      default: begin
      end
    endcase
    o.front_value = has_words ? deque_words[front_ix] : ade_pkg::EMPTY_WORD;
    o.back_value = has_words ? deque_words[back_ix] : ade_pkg::EMPTY_WORD;
    o.count = has_words ? ade_pkg::CNT_W'(back_ix - front_ix + 1) : '0;
    o.is_empty = !has_words;
    return o;
  endfunction

  // Queues one request and widens the cycle limit by what it can cost. Reverse and sort
  // walk the stored words, so they get room for several full quadratic insertion sorts.
  function automatic void add_req(logic [2:0] code, ade_pkg::word_t value);
    ade_pkg::req_t r;
    r.req_type = code;
    r.push_value = value;
    if (n_pending >= MAX_ITEMS) begin
      return;
    end
    pending_reqs[n_pending] = r;
    n_pending++;
    cycle_limit += 60;
    if (code == ade_pkg::REQ_REVERSE || code == ade_pkg::REQ_SORT) begin
      cycle_limit += 4 * (ade_pkg::DEPTH * ade_pkg::DEPTH + 4 * ade_pkg::DEPTH);
    end
  endfunction

  // Half full-range words, the rest the extremes, -1, 0 and a narrow band that makes duplicates.
  function automatic ade_pkg::word_t pick_word();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '1;
      3: return '0;
      4: return ade_pkg::word_t'($urandom_range(15)) - 8;
      default: return ade_pkg::word_t'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 22) return ade_pkg::REQ_PUSH_FRONT;
    if (r < 47) return ade_pkg::REQ_PUSH_BACK;
    if (r < 62) return ade_pkg::REQ_POP_FRONT;
    if (r < 77) return ade_pkg::REQ_POP_BACK;
    if (r < 80) return ade_pkg::REQ_CLEAR;
    if (r < 88) return ade_pkg::REQ_REVERSE;
    if (r < 94) return ade_pkg::REQ_SORT;
    if (r < 97) return REQ_UNUSED;
    return ade_pkg::REQ_PUSH_BACK;
  endfunction

  // Driver: a new beat is offered only when the slot is free, so valid holds until taken.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        expected_rsps[exp_wr] = apply_request(req);
        exp_wr++;
        sent_count++;
      end
      if (!req_valid || req_ready) begin
        if (next_pending < n_pending &&
            ((sent_count >= CALM_FROM && sent_count < CALM_TO) ||
             $urandom_range(99) >= IDLE_PCT)) begin
          req <= pending_reqs[next_pending];
          next_pending++;
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every response beat is checked against the oldest expectation.
  always @(posedge clk) begin
    ade_pkg::rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        got_count++;
        if (exp_rd == exp_wr) begin
          failures++;
          if (failures <= MAX_REPORTS) begin
            $display("unexpected response: st=%0d front=%0d back=%0d cnt=%0d empty=%0b",
                     rsp.status, rsp.front_value, rsp.back_value, rsp.count, rsp.is_empty);
          end
        end else begin
          want = expected_rsps[exp_rd];
          exp_rd++;
          if (rsp.status !== want.status || rsp.front_value !== want.front_value ||
              rsp.back_value !== want.back_value || rsp.count !== want.count ||
              rsp.is_empty !== want.is_empty) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
              $display("response %0d mismatch: exp st=%0d front=%0d back=%0d cnt=%0d empty=%0b",
                       got_count, want.status, want.front_value, want.back_value,
                       want.count, want.is_empty);
              $display("                        got st=%0d front=%0d back=%0d cnt=%0d empty=%0b",
                       rsp.status, rsp.front_value, rsp.back_value, rsp.count, rsp.is_empty);
            end
          end
        end
      end
      rsp_ready <= (got_count >= CALM_FROM && got_count < CALM_TO) ||
                   $urandom_range(99) >= IDLE_PCT;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int n_random;
    int n;
    int i;
    int kind;

    // Directed part: empty-deque corner cases first, then both overflow-free pushes,
    // the front overflow at slot 0, sort and reverse on a mixed set, and the pops
    // that take the deque back to empty.
    add_req(ade_pkg::REQ_POP_FRONT, 32'h1234_5678);
    add_req(ade_pkg::REQ_POP_BACK, '1);
    add_req(ade_pkg::REQ_REVERSE, '0);
    add_req(ade_pkg::REQ_SORT, '0);
    add_req(REQ_UNUSED, 32'h7fff_ffff);
    add_req(ade_pkg::REQ_PUSH_FRONT, 32'h7fff_ffff);
    add_req(ade_pkg::REQ_PUSH_FRONT, 32'h8000_0000);
    add_req(ade_pkg::REQ_PUSH_BACK, 32'h8000_0000);
    add_req(ade_pkg::REQ_PUSH_BACK, '1);
    add_req(ade_pkg::REQ_PUSH_BACK, '0);
    add_req(ade_pkg::REQ_PUSH_BACK, 32'sd5);
    add_req(ade_pkg::REQ_SORT, '0);
    add_req(ade_pkg::REQ_REVERSE, '0);
    add_req(REQ_UNUSED, '0);
    add_req(ade_pkg::REQ_POP_FRONT, '0);
    add_req(ade_pkg::REQ_PUSH_FRONT, 32'h5a5a_a5a5);
    add_req(ade_pkg::REQ_POP_BACK, '0);
    add_req(ade_pkg::REQ_CLEAR, '0);
    add_req(ade_pkg::REQ_CLEAR, '0);
    add_req(ade_pkg::REQ_PUSH_BACK, -32'sd7);
    add_req(ade_pkg::REQ_POP_BACK, '0);
    add_req(ade_pkg::REQ_PUSH_FRONT, 32'sd9);
    add_req(ade_pkg::REQ_POP_FRONT, '0);
    add_req(ade_pkg::REQ_POP_FRONT, '0);

    // Random part: long fill runs reach the back overflow and the costly sorts, drain
    // runs reach underflow, and short mixed runs cover everything in between.
    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 20) begin
        n = $urandom_range(100, 135);
        for (i = 0; i < n; i++) add_req(ade_pkg::REQ_PUSH_BACK, pick_word());
        n_random += n;
        add_req($urandom_range(1) ? ade_pkg::REQ_SORT : ade_pkg::REQ_REVERSE,
                ade_pkg::word_t'($urandom));
        n = $urandom_range(1, 40);
        for (i = 0; i < n; i++) add_req(ade_pkg::REQ_POP_FRONT, ade_pkg::word_t'($urandom));
        // Up to three more front pushes than pops so the front can run into slot 0.
        n += $urandom_range(0, 3);
        for (i = 0; i < n; i++) add_req(ade_pkg::REQ_PUSH_FRONT, pick_word());
        n_random += 2 * n + 1;
      end else if (kind < 30) begin
        n = $urandom_range(1, 140);
        for (i = 0; i < n; i++) begin
          add_req($urandom_range(1) ? ade_pkg::REQ_POP_FRONT : ade_pkg::REQ_POP_BACK,
                  ade_pkg::word_t'($urandom));
        end
        n_random += n;
      end else begin
        if (kind < 36) begin
          add_req(ade_pkg::REQ_CLEAR, ade_pkg::word_t'($urandom));
          n_random++;
        end
        n = $urandom_range(10, 40);
        for (i = 0; i < n; i++) add_req(pick_op(), pick_word());
        n_random += n;
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (next_pending < n_pending || req_valid || exp_rd != exp_wr) begin
      @(posedge clk);
    end
    // Keep the clock running so that a stray extra response would still be caught.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
